// ===== sv/qshs_pkg.sv =====
// qshs_pkg: shared types and constants of the quadric surface height solver
// no dependencies; imported by the cells and the top level
package qshs_pkg;

    // intermediate values saturate to +-(2^62 - 1)
    localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ST_QUAD   = 2'd0,
        ST_LIN    = 2'd1,
        ST_DEGEN  = 2'd2,
        ST_NOROOT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_XX_YY   = 3'd0,
        REG_ZZ_XY   = 3'd1,
        REG_YZ_XZ   = 3'd2,
        REG_LIN_XY  = 3'd3,
        REG_LIN_ZC  = 3'd4,
        REG_THRESH  = 3'd5
    } cfg_reg_t;

    // side data that travels with an item through the cell chains
    typedef struct packed {
        logic              vld;
        status_t           status;
        logic              neg;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
    } side_t;

    // 32 by 32 partial products of a magnitude product, with the product sign
    typedef struct packed {
        logic        neg;
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
    } mul_pp_t;

endpackage

// ===== sv/qshs_sqrt_cell.sv =====
// qshs_sqrt_cell: one restoring square root step, two radicand bits per cell
// depends on qshs_pkg
module qshs_sqrt_cell
    import qshs_pkg::*;
#(
    parameter int RAD_W = 78,
    parameter int ROOT_W = 39
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad_in,
    input  logic [ROOT_W+1:0] rem_in,
    input  logic [ROOT_W-1:0] root_in,
    input  side_t             side_in,
    output logic [RAD_W-1:0]  rad_out,
    output logic [ROOT_W+1:0] rem_out,
    output logic [ROOT_W-1:0] root_out,
    output side_t             side_out
);

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              take;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    side_t             side_reg;

    always_comb begin
        rem_sh = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1:RAD_W-2]};
        trial  = {root_in, 2'b01};
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.vld <= 1'b0;
        end else if (en) begin
            side_reg <= side_in;
        end
        if (en) begin
            rad_reg  <= {rad_in[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_in[ROOT_W-2:0], take};
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

// ===== sv/qshs_div_cell.sv =====
// qshs_div_cell: one restoring division step, one quotient bit per cell
// depends on qshs_pkg
module qshs_div_cell
    import qshs_pkg::*;
#(
    parameter int DIV_W = 78
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [DIV_W-1:0] num_in,
    input  logic [63:0]      rem_in,
    input  logic [DIV_W-1:0] quo_in,
    input  logic [63:0]      den_in,
    input  side_t            side_in,
    output logic [DIV_W-1:0] num_out,
    output logic [63:0]      rem_out,
    output logic [DIV_W-1:0] quo_out,
    output logic [63:0]      den_out,
    output side_t            side_out
);

    logic [63:0]      rem_sh;
    logic             take;
    logic [DIV_W-1:0] num_reg;
    logic [63:0]      rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [63:0]      den_reg;
    side_t            side_reg;

    always_comb begin
        rem_sh = {rem_in[62:0], num_in[DIV_W-1]};
        take   = (rem_sh >= den_in);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.vld <= 1'b0;
        end else if (en) begin
            side_reg <= side_in;
        end
        if (en) begin
            num_reg <= {num_in[DIV_W-2:0], 1'b0};
            rem_reg <= take ? (rem_sh - den_in) : rem_sh;
            quo_reg <= {quo_in[DIV_W-2:0], take};
            den_reg <= den_in;
        end
    end

    assign num_out  = num_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign den_out  = den_reg;
    assign side_out = side_reg;

endmodule

// ===== sv/quadric_surface_height_solver_core.sv =====
// quadric_surface_height_solver_core: top level of the quadric height solver
// depends on qshs_pkg, qshs_sqrt_cell and qshs_div_cell
//
// For each point (pos_x, pos_y) in signed fixed point the core solves the
// configured quadric for z: A = czz, B = cyz*y + cxz*x + cz, and C from the
// remaining terms. With |A| below the threshold it returns -C/B (status 1),
// or 0 with status 2 when B is also small; otherwise the smaller root of
// A*z^2 + B*z + C (status 0), or 0 with status 3 on a negative discriminant.
// Results beyond the coordinate range are clipped and flagged. One point is
// taken each cycle the pipe advances; it holds 8 front stages (every product
// is split into 32 by 32 partial products in one stage and summed in the
// next), one discriminant stage, (62+FRAC_BITS+1)/2 square root cells, one
// setup stage, 62+FRAC_BITS divider cells and the output register. The whole
// pipe advances whenever the output register is empty or being taken, so a
// stall on m_ready holds every stage. The user must write configuration
// through a plain write port only while idle; the core does not enforce it.
module quadric_surface_height_solver_core
    import qshs_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [63:0]                   cfg_data,
    // point input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  logic signed [COORD_WIDTH-1:0] s_pos_y,
    // height output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_height_z,
    output logic [1:0]                    m_solve_status,
    output logic                          m_saturated
);

    localparam int SQ_ITERS = (62 + FRAC_BITS + 1) / 2;
    localparam int RAD_W    = 2 * SQ_ITERS;
    localparam int DIV_W    = 62 + FRAC_BITS;
    localparam logic signed [63:0] ZMAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] ZMIN = -ZMAX - 64'sd1;

    function automatic logic [63:0] umag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // first half of a fixed point product: partial products of the magnitudes
    function automatic mul_pp_t mul_split(input logic signed [63:0] p,
                                          input logic signed [63:0] q);
        logic [63:0] up;
        logic [63:0] uq;
        mul_pp_t     r;
        up    = umag(p);
        uq    = umag(q);
        r.neg = (p[63] != q[63]);
        r.p00 = 64'(up[31:0]) * 64'(uq[31:0]);
        r.p01 = 64'(up[31:0]) * 64'(uq[63:32]);
        r.p10 = 64'(up[63:32]) * 64'(uq[31:0]);
        r.p11 = 64'(up[63:32]) * 64'(uq[63:32]);
        return r;
    endfunction

    // second half: sum the partials, truncate, saturate, then apply the sign
    function automatic logic signed [63:0] mul_fin(input mul_pp_t pp);
        logic [127:0] prod;
        logic [127:0] sh;
        logic [63:0]  r;
        prod = 128'(pp.p00) + (128'(pp.p01) << 32) + (128'(pp.p10) << 32)
             + {pp.p11, 64'd0};
        sh   = prod >> FRAC_BITS;
        r    = (sh > {64'd0, LIM}) ? LIM : sh[63:0];
        return pp.neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] p,
                                                input logic signed [63:0] q);
        logic signed [64:0] s;
        s = {p[63], p} + {q[63], q};
        if (s > 65'(LIM)) return LIM;
        if (s < -65'(LIM)) return -LIM;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] half(input logic [63:0] v, input logic hi);
        logic signed [31:0] h;
        h = hi ? v[63:32] : v[31:0];
        return 64'(h);
    endfunction

    // configuration registers
    logic [63:0] coeff_xx_yy_reg;
    logic [63:0] coeff_zz_xy_reg;
    logic [63:0] coeff_yz_xz_reg;
    logic [63:0] coeff_lin_x_y_reg;
    logic [63:0] coeff_lin_z_const_reg;
    logic [15:0] thresh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_xx_yy_reg       <= '0;
            coeff_zz_xy_reg       <= '0;
            coeff_yz_xz_reg       <= '0;
            coeff_lin_x_y_reg     <= '0;
            coeff_lin_z_const_reg <= '0;
            thresh_reg            <= 16'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_XX_YY:  coeff_xx_yy_reg       <= cfg_data;
                REG_ZZ_XY:  coeff_zz_xy_reg       <= cfg_data;
                REG_YZ_XZ:  coeff_yz_xz_reg       <= cfg_data;
                REG_LIN_XY: coeff_lin_x_y_reg     <= cfg_data;
                REG_LIN_ZC: coeff_lin_z_const_reg <= cfg_data;
                REG_THRESH: thresh_reg            <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // pipe advance: output empty or its transfer happening
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic signed [63:0] x_in;
    logic signed [63:0] y_in;
    assign x_in = 64'(s_pos_x);
    assign y_in = 64'(s_pos_y);

    // stage 1: partial products of the coordinate terms
    logic               v1_reg;
    mul_pp_t            xx_pp_reg, yy_pp_reg, xy_pp_reg, lx_pp_reg, ly_pp_reg;
    mul_pp_t            by_pp_reg, bx_pp_reg;
    // stage 2: coordinate products and linear terms
    logic               v2_reg;
    logic signed [63:0] xx_reg, yy_reg, xy_reg, lx_reg, ly_reg, by_reg, bx_reg;
    // stage 3: partial products of the quadratic terms of C, B complete
    logic               v3_reg;
    mul_pp_t            t1_pp_reg, t2_pp_reg, t3_pp_reg;
    logic signed [63:0] lx3_reg, ly3_reg, b3_reg;
    // stage 4: quadratic terms of C
    logic               v4_reg;
    logic signed [63:0] t1_reg, t2_reg, t3_reg, lx4_reg, ly4_reg, b4_reg;
    // stage 5: quadratic part of C
    logic               v5_reg;
    logic signed [63:0] cq_reg, lx5_reg, ly5_reg, b5_reg;
    // stage 6: C complete
    logic               v6_reg;
    logic signed [63:0] b6_reg, c6_reg;
    // stage 7: partial products of A*C and B*B, near-zero tests
    logic               v7_reg;
    mul_pp_t            ac_pp_reg, bb_pp_reg;
    logic signed [63:0] b7_reg, c7_reg;
    logic               nza7_reg, nzb7_reg;
    // stage 8: A*C and B*B
    logic               v8_reg;
    logic signed [63:0] b8_reg, c8_reg, ac_reg, bb_reg;
    logic               nza_reg, nzb_reg;

    logic signed [63:0] a_coef;
    assign a_coef = half(coeff_zz_xy_reg, 1'b0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
        if (en) begin
            xx_pp_reg <= mul_split(x_in, x_in);
            yy_pp_reg <= mul_split(y_in, y_in);
            xy_pp_reg <= mul_split(x_in, y_in);
            lx_pp_reg <= mul_split(half(coeff_lin_x_y_reg, 1'b0), x_in);
            ly_pp_reg <= mul_split(half(coeff_lin_x_y_reg, 1'b1), y_in);
            by_pp_reg <= mul_split(half(coeff_yz_xz_reg, 1'b0), y_in);
            bx_pp_reg <= mul_split(half(coeff_yz_xz_reg, 1'b1), x_in);

            xx_reg  <= mul_fin(xx_pp_reg);
            yy_reg  <= mul_fin(yy_pp_reg);
            xy_reg  <= mul_fin(xy_pp_reg);
            lx_reg  <= mul_fin(lx_pp_reg);
            ly_reg  <= mul_fin(ly_pp_reg);
            by_reg  <= mul_fin(by_pp_reg);
            bx_reg  <= mul_fin(bx_pp_reg);

            t1_pp_reg <= mul_split(half(coeff_xx_yy_reg, 1'b0), xx_reg);
            t2_pp_reg <= mul_split(half(coeff_xx_yy_reg, 1'b1), yy_reg);
            t3_pp_reg <= mul_split(half(coeff_zz_xy_reg, 1'b1), xy_reg);
            lx3_reg   <= lx_reg;
            ly3_reg   <= ly_reg;
            b3_reg    <= sadd(sadd(by_reg, bx_reg), half(coeff_lin_z_const_reg, 1'b0));

            t1_reg  <= mul_fin(t1_pp_reg);
            t2_reg  <= mul_fin(t2_pp_reg);
            t3_reg  <= mul_fin(t3_pp_reg);
            lx4_reg <= lx3_reg;
            ly4_reg <= ly3_reg;
            b4_reg  <= b3_reg;

            // C is summed left to right, saturating at each step
            cq_reg  <= sadd(sadd(t1_reg, t2_reg), t3_reg);
            lx5_reg <= lx4_reg;
            ly5_reg <= ly4_reg;
            b5_reg  <= b4_reg;

            c6_reg  <= sadd(sadd(sadd(cq_reg, lx5_reg), ly5_reg),
                            half(coeff_lin_z_const_reg, 1'b1));
            b6_reg  <= b5_reg;

            ac_pp_reg <= mul_split(a_coef, c6_reg);
            bb_pp_reg <= mul_split(b6_reg, b6_reg);
            b7_reg    <= b6_reg;
            c7_reg    <= c6_reg;
            nza7_reg  <= (a_coef == 64'sd0) || (umag(a_coef) < 64'(thresh_reg));
            nzb7_reg  <= (b6_reg == 64'sd0) || (umag(b6_reg) < 64'(thresh_reg));

            ac_reg  <= mul_fin(ac_pp_reg);
            bb_reg  <= mul_fin(bb_pp_reg);
            b8_reg  <= b7_reg;
            c8_reg  <= c7_reg;
            nza_reg <= nza7_reg;
            nzb_reg <= nzb7_reg;
        end
    end

    // stage 9: discriminant, branch choice, square root radicand
    logic signed [63:0] four_ac;
    logic signed [63:0] disc;
    status_t            st9;
    side_t              side9_reg;
    logic [RAD_W-1:0]   rad9_reg;

    always_comb begin
        four_ac = sadd(sadd(ac_reg, ac_reg), sadd(ac_reg, ac_reg));
        disc    = sadd(bb_reg, -four_ac);
        if (nza_reg) begin
            st9 = nzb_reg ? ST_DEGEN : ST_LIN;
        end else begin
            st9 = disc[63] ? ST_NOROOT : ST_QUAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side9_reg.vld <= 1'b0;
        end else if (en) begin
            side9_reg.vld <= v8_reg;
        end
        if (en) begin
            side9_reg.status <= st9;
            side9_reg.neg    <= 1'b0;
            side9_reg.a      <= a_coef;
            side9_reg.b      <= b8_reg;
            side9_reg.c      <= c8_reg;
            rad9_reg         <= (st9 == ST_QUAD) ? (RAD_W'(disc) << FRAC_BITS) : '0;
        end
    end

    // square root chain, two radicand bits per cell
    logic [RAD_W-1:0]    sq_rad  [0:SQ_ITERS];
    logic [SQ_ITERS+1:0] sq_rem  [0:SQ_ITERS];
    logic [SQ_ITERS-1:0] sq_root [0:SQ_ITERS];
    side_t               sq_side [0:SQ_ITERS];

    assign sq_rad[0]  = rad9_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = side9_reg;

    for (genvar i = 0; i < SQ_ITERS; i++) begin : g_sqrt
        qshs_sqrt_cell #(
            .RAD_W  (RAD_W),
            .ROOT_W (SQ_ITERS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .rad_in   (sq_rad[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .side_in  (sq_side[i]),
            .rad_out  (sq_rad[i+1]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1]),
            .side_out (sq_side[i+1])
        );
    end

    // setup stage: numerator and denominator for the divider
    side_t              sq_last;
    logic signed [63:0] sroot;
    logic signed [63:0] num_s;
    logic signed [63:0] den_s;
    side_t              side_s_reg;
    logic [DIV_W-1:0]   num_s_reg;
    logic [63:0]        den_s_reg;

    always_comb begin
        sq_last = sq_side[SQ_ITERS];
        sroot   = 64'(sq_root[SQ_ITERS]);
        case (sq_last.status)
            ST_QUAD: begin
                num_s = (!sq_last.a[63]) ? sadd(-sq_last.b, -sroot)
                                         : sadd(-sq_last.b, sroot);
                den_s = sadd(sq_last.a, sq_last.a);
            end
            ST_LIN: begin
                num_s = -sq_last.c;
                den_s = sq_last.b;
            end
            default: begin
                // no division: zero over one gives a zero height
                num_s = 64'sd0;
                den_s = 64'sd1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_s_reg.vld <= 1'b0;
        end else if (en) begin
            side_s_reg.vld <= sq_last.vld;
        end
        if (en) begin
            side_s_reg.status <= sq_last.status;
            side_s_reg.neg    <= (num_s[63] != den_s[63]);
            side_s_reg.a      <= sq_last.a;
            side_s_reg.b      <= sq_last.b;
            side_s_reg.c      <= sq_last.c;
            num_s_reg         <= DIV_W'(umag(num_s)) << FRAC_BITS;
            den_s_reg         <= umag(den_s);
        end
    end

    // divider chain, one quotient bit per cell
    logic [DIV_W-1:0] dv_num  [0:DIV_W];
    logic [63:0]      dv_rem  [0:DIV_W];
    logic [DIV_W-1:0] dv_quo  [0:DIV_W];
    logic [63:0]      dv_den  [0:DIV_W];
    side_t            dv_side [0:DIV_W];

    assign dv_num[0]  = num_s_reg;
    assign dv_rem[0]  = '0;
    assign dv_quo[0]  = '0;
    assign dv_den[0]  = den_s_reg;
    assign dv_side[0] = side_s_reg;

    for (genvar j = 0; j < DIV_W; j++) begin : g_div
        qshs_div_cell #(
            .DIV_W (DIV_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .num_in   (dv_num[j]),
            .rem_in   (dv_rem[j]),
            .quo_in   (dv_quo[j]),
            .den_in   (dv_den[j]),
            .side_in  (dv_side[j]),
            .num_out  (dv_num[j+1]),
            .rem_out  (dv_rem[j+1]),
            .quo_out  (dv_quo[j+1]),
            .den_out  (dv_den[j+1]),
            .side_out (dv_side[j+1])
        );
    end

    // output stage: quotient saturation, sign, clip to coordinate range
    side_t              dv_last;
    logic [63:0]        q_mag;
    logic signed [63:0] z_full;
    logic signed [COORD_WIDTH-1:0] z_next;
    logic               sat_next;
    logic signed [COORD_WIDTH-1:0] z_reg;
    status_t            status_reg;
    logic               sat_reg;

    always_comb begin
        dv_last = dv_side[DIV_W];
        q_mag   = (dv_quo[DIV_W] > DIV_W'(LIM)) ? LIM : 64'(dv_quo[DIV_W]);
        z_full  = dv_last.neg ? -$signed(q_mag) : $signed(q_mag);
        if (z_full > ZMAX) begin
            z_next   = COORD_WIDTH'(ZMAX);
            sat_next = 1'b1;
        end else if (z_full < ZMIN) begin
            z_next   = COORD_WIDTH'(ZMIN);
            sat_next = 1'b1;
        end else begin
            z_next   = COORD_WIDTH'(z_full);
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_last.vld;
        end
        if (en) begin
            z_reg      <= z_next;
            status_reg <= dv_last.status;
            sat_reg    <= sat_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_height_z     = z_reg;
    assign m_solve_status = status_reg;
    assign m_saturated    = sat_reg;

endmodule
